// ----- src/stop_and_wait_reliable_session_core_defines.svh -----
// Assertion macros for the stop-and-wait reliable session core.
`ifndef STOP_AND_WAIT_RELIABLE_SESSION_CORE_DEFINES_SVH
`define STOP_AND_WAIT_RELIABLE_SESSION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, muted during reset.
`define SWRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("session core check failed");

// Next-cycle implication, sampled on aclk, muted during reset.
`define SWRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("session core check failed");

`endif

// ----- src/swrc_pkg.sv -----
// Shared types and constants of the reliable session core.
package swrc_pkg;

    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_RX   = 2'd2;
    localparam logic [1:0] FUNC_ACK  = 2'd3;

    localparam logic [3:0] ACT_TX      = 4'd0;
    localparam logic [3:0] ACT_RETX    = 4'd1;
    localparam logic [3:0] ACT_DROP    = 4'd2;
    localparam logic [3:0] ACT_ACK     = 4'd3;
    localparam logic [3:0] ACT_DELIVER = 4'd4;
    localparam logic [3:0] ACT_DUP     = 4'd5;
    localparam logic [3:0] ACT_RESET   = 4'd6;
    localparam logic [3:0] ACT_TIMEOUT = 4'd7;
    localparam logic [3:0] ACT_FULL    = 4'd8;
    localparam logic [3:0] ACT_CONNECT = 4'd9;

    localparam logic [1:0] SER_ITEM  = 2'd0;
    localparam logic [1:0] SER_ZERO  = 2'd1;
    localparam logic [1:0] SER_AWAIT = 2'd2;
    localparam logic [1:0] SER_QUEUE = 2'd3;

    localparam logic [1:0] REL_ITEM  = 2'd0;
    localparam logic [1:0] REL_ONE   = 2'd1;
    localparam logic [1:0] REL_ZERO  = 2'd2;
    localparam logic [1:0] REL_QUEUE = 2'd3;

    localparam logic [1:0] CFG_RESEND   = 2'd0;
    localparam logic [1:0] CFG_RELIABLE = 2'd1;
    localparam logic [1:0] CFG_PEER     = 2'd2;

    localparam logic [23:0] RESEND_RST   = 24'd500;
    localparam logic [23:0] RELIABLE_RST = 24'd60000;
    localparam logic [23:0] PEER_RST     = 24'd60000;

    localparam logic [30:0] RESET_WINDOW = 31'd10;
    localparam logic [4:0]  MAX_RESULTS  = 5'd16;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [3:0] act;
        logic [1:0] ser_sel;
        logic [1:0] rel_sel;
        logic       open_sess;
        logic       open_rx;
        logic       close_sess;
        logic       fifo_push;
        logic       fifo_rd;
        logic       fifo_pop;
        logic       tick_age;
        logic       tick_retx;
        logic       clr_await;
        logic       clr_silence;
        logic       set_rs;
        logic       finish;
    } swrc_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       ser_zero;
        logic       rel;
        logic       peer_known;
        logic       awaiting;
        logic       fifo_full;
        logic       fifo_empty;
        logic       n_full;
        logic       age_expired;
        logic       countdown_zero;
        logic       silence_expired;
        logic       reset_hit;
        logic       ser_gt_rs;
        logic       ack_match;
        logic       emit_ok;
        logic       out_free;
        logic       pend_valid;
    } swrc_status_t;

endpackage

// ----- src/swrc_ctrl.sv -----
// Sequencing state machine of the reliable session core.
module swrc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  swrc_pkg::swrc_status_t st,
    output swrc_pkg::swrc_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_SEND      = 4'd2;
    localparam logic [3:0] S_TICK_AGE  = 4'd3;
    localparam logic [3:0] S_TICK_EVT  = 4'd4;
    localparam logic [3:0] S_TICK_SIL  = 4'd5;
    localparam logic [3:0] S_RX        = 4'd6;
    localparam logic [3:0] S_RX_DLV    = 4'd7;
    localparam logic [3:0] S_DRAIN_CHK = 4'd8;
    localparam logic [3:0] S_DRAIN_TX  = 4'd9;
    localparam logic [3:0] S_FINISH    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.emit_ok) begin
                    unique case (st.func)
                        swrc_pkg::FUNC_SEND: begin
                            if (st.ser_zero) begin
                                cmd.emit    = 1'b1;
                                cmd.act     = swrc_pkg::ACT_TX;
                                cmd.ser_sel = swrc_pkg::SER_ZERO;
                                cmd.rel_sel = swrc_pkg::REL_ITEM;
                                state_next  = S_FINISH;
                            end else begin
                                if (!st.peer_known) begin
                                    cmd.emit      = 1'b1;
                                    cmd.act       = swrc_pkg::ACT_CONNECT;
                                    cmd.ser_sel   = swrc_pkg::SER_ITEM;
                                    cmd.rel_sel   = swrc_pkg::REL_ZERO;
                                    cmd.open_sess = 1'b1;
                                end
                                state_next = S_SEND;
                            end
                        end
                        swrc_pkg::FUNC_TICK: begin
                            state_next = st.peer_known ? S_TICK_AGE : S_FINISH;
                        end
                        swrc_pkg::FUNC_RX: begin
                            if (!st.peer_known) begin
                                cmd.emit      = 1'b1;
                                cmd.act       = swrc_pkg::ACT_CONNECT;
                                cmd.ser_sel   = swrc_pkg::SER_ITEM;
                                cmd.rel_sel   = swrc_pkg::REL_ZERO;
                                cmd.open_sess = 1'b1;
                                cmd.open_rx   = 1'b1;
                            end
                            state_next = S_RX;
                        end
                        default: begin
                            if (st.ack_match) begin
                                cmd.clr_await   = 1'b1;
                                cmd.clr_silence = 1'b1;
                            end
                            state_next = S_DRAIN_CHK;
                        end
                    endcase
                end
            end
            S_SEND: begin
                if (st.emit_ok) begin
                    if (st.fifo_full) begin
                        cmd.emit    = 1'b1;
                        cmd.act     = swrc_pkg::ACT_FULL;
                        cmd.ser_sel = swrc_pkg::SER_ITEM;
                        cmd.rel_sel = swrc_pkg::REL_ITEM;
                    end else begin
                        cmd.fifo_push = 1'b1;
                    end
                    state_next = S_DRAIN_CHK;
                end
            end
            S_TICK_AGE: begin
                cmd.tick_age = 1'b1;
                state_next   = S_TICK_EVT;
            end
            S_TICK_EVT: begin
                if (st.emit_ok) begin
                    if (st.awaiting && st.age_expired) begin
                        cmd.emit      = 1'b1;
                        cmd.act       = swrc_pkg::ACT_DROP;
                        cmd.ser_sel   = swrc_pkg::SER_AWAIT;
                        cmd.rel_sel   = swrc_pkg::REL_ONE;
                        cmd.clr_await = 1'b1;
                    end else if (st.awaiting && st.countdown_zero) begin
                        cmd.emit      = 1'b1;
                        cmd.act       = swrc_pkg::ACT_RETX;
                        cmd.ser_sel   = swrc_pkg::SER_AWAIT;
                        cmd.rel_sel   = swrc_pkg::REL_ONE;
                        cmd.tick_retx = 1'b1;
                    end
                    state_next = S_TICK_SIL;
                end
            end
            S_TICK_SIL: begin
                if (st.emit_ok) begin
                    if (st.silence_expired) begin
                        cmd.emit       = 1'b1;
                        cmd.act        = swrc_pkg::ACT_TIMEOUT;
                        cmd.ser_sel    = swrc_pkg::SER_ZERO;
                        cmd.rel_sel    = swrc_pkg::REL_ZERO;
                        cmd.close_sess = 1'b1;
                        state_next     = S_FINISH;
                    end else begin
                        state_next = S_DRAIN_CHK;
                    end
                end
            end
            S_RX: begin
                if (st.emit_ok) begin
                    cmd.clr_silence = 1'b1;
                    if (st.reset_hit) begin
                        cmd.emit       = 1'b1;
                        cmd.act        = swrc_pkg::ACT_RESET;
                        cmd.ser_sel    = swrc_pkg::SER_ITEM;
                        cmd.rel_sel    = swrc_pkg::REL_ZERO;
                        cmd.close_sess = 1'b1;
                        state_next     = S_FINISH;
                    end else begin
                        if (st.rel) begin
                            cmd.emit    = 1'b1;
                            cmd.act     = swrc_pkg::ACT_ACK;
                            cmd.ser_sel = swrc_pkg::SER_ITEM;
                            cmd.rel_sel = swrc_pkg::REL_ZERO;
                        end
                        state_next = S_RX_DLV;
                    end
                end
            end
            S_RX_DLV: begin
                if (st.emit_ok) begin
                    cmd.emit    = 1'b1;
                    cmd.ser_sel = swrc_pkg::SER_ITEM;
                    cmd.rel_sel = swrc_pkg::REL_ZERO;
                    if (st.ser_gt_rs) begin
                        cmd.act    = swrc_pkg::ACT_DELIVER;
                        cmd.set_rs = 1'b1;
                    end else begin
                        cmd.act = swrc_pkg::ACT_DUP;
                    end
                    state_next = S_DRAIN_CHK;
                end
            end
            S_DRAIN_CHK: begin
                if (st.peer_known && !st.awaiting && !st.fifo_empty && !st.n_full) begin
                    cmd.fifo_rd = 1'b1;
                    state_next  = S_DRAIN_TX;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_DRAIN_TX: begin
                if (st.emit_ok) begin
                    cmd.emit     = 1'b1;
                    cmd.act      = swrc_pkg::ACT_TX;
                    cmd.ser_sel  = swrc_pkg::SER_QUEUE;
                    cmd.rel_sel  = swrc_pkg::REL_QUEUE;
                    cmd.fifo_pop = 1'b1;
                    state_next   = S_DRAIN_CHK;
                end
            end
            S_FINISH: begin
                if (!st.pend_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/swrc_dp.sv -----
// Session state, send queue, timers and result registers of the session core.
module swrc_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swrc_pkg::swrc_cmd_t    cmd,
    output swrc_pkg::swrc_status_t st,
    input  logic [47:0]            s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [23:0]            cfg_wdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,
    output logic [3:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(QUEUE_DEPTH - 1);

    logic [23:0] resend_reg, reliable_reg, peer_reg;

    logic [1:0]  func_reg;
    logic [30:0] ser_reg;
    logic        rel_reg;
    logic [15:0] el_reg;

    logic        peer_known_reg, awaiting_reg;
    logic [30:0] rs_reg, awaited_reg;
    logic [23:0] cd_reg, age_reg, silence_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [4:0]  n_reg;

    logic [31:0] mem [QUEUE_DEPTH];
    logic [31:0] rd_reg;

    logic        pend_valid_reg;
    logic [3:0]  pend_act_reg;
    logic [30:0] pend_ser_reg;
    logic        pend_rel_reg;

    logic        out_valid_reg, out_last_reg, out_rel_reg;
    logic [3:0]  out_act_reg;
    logic [30:0] out_ser_reg;

    logic [23:0] el24;
    logic [24:0] age_sum, sil_sum;
    logic [23:0] age_sat, sil_sat, cd_dec;
    logic [AW:0] tail_sum;
    logic [AW-1:0] tail_ix, head_next;
    logic [30:0] ser_mux, rs_diff, rs_open;
    logic        rel_mux, out_free;

    assign el24    = {8'd0, el_reg};
    assign age_sum = {1'b0, age_reg} + {1'b0, el24};
    assign sil_sum = {1'b0, silence_reg} + {1'b0, el24};
    assign age_sat = age_sum[24] ? '1 : age_sum[23:0];
    assign sil_sat = sil_sum[24] ? '1 : sil_sum[23:0];
    assign cd_dec  = (cd_reg > el24) ? (cd_reg - el24) : 24'd0;

    assign tail_sum  = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail_ix   = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
    assign head_next = (head_reg == LAST_IX) ? '0 : head_reg + 1'b1;

    assign rs_diff = rs_reg - ser_reg;
    assign rs_open = (cmd.open_rx && ser_reg != 31'd0) ? ser_reg - 31'd1 : 31'd0;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        case (cmd.ser_sel)
            swrc_pkg::SER_ITEM:  ser_mux = ser_reg;
            swrc_pkg::SER_AWAIT: ser_mux = awaited_reg;
            swrc_pkg::SER_QUEUE: ser_mux = rd_reg[30:0];
            default:             ser_mux = 31'd0;
        endcase
        case (cmd.rel_sel)
            swrc_pkg::REL_ITEM:  rel_mux = rel_reg;
            swrc_pkg::REL_ONE:   rel_mux = 1'b1;
            swrc_pkg::REL_QUEUE: rel_mux = rd_reg[31];
            default:             rel_mux = 1'b0;
        endcase
    end

    always_comb begin
        st.func            = func_reg;
        st.ser_zero        = (ser_reg == 31'd0);
        st.rel             = rel_reg;
        st.peer_known      = peer_known_reg;
        st.awaiting        = awaiting_reg;
        st.fifo_full       = (count_reg == DEPTH_C);
        st.fifo_empty      = (count_reg == '0);
        st.n_full          = (n_reg >= swrc_pkg::MAX_RESULTS);
        st.age_expired     = (age_reg >= reliable_reg);
        st.countdown_zero  = (cd_reg == 24'd0);
        st.silence_expired = (silence_reg >= peer_reg);
        st.reset_hit       = (ser_reg < rs_reg) &&
                             (ser_reg <= swrc_pkg::RESET_WINDOW ||
                              rs_diff > swrc_pkg::RESET_WINDOW);
        st.ser_gt_rs       = (ser_reg > rs_reg);
        st.ack_match       = peer_known_reg && awaiting_reg && (awaited_reg == ser_reg);
        st.emit_ok         = !pend_valid_reg || out_free;
        st.out_free        = out_free;
        st.pend_valid      = pend_valid_reg;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resend_reg   <= swrc_pkg::RESEND_RST;
            reliable_reg <= swrc_pkg::RELIABLE_RST;
            peer_reg     <= swrc_pkg::PEER_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                swrc_pkg::CFG_RESEND:   resend_reg   <= cfg_wdata;
                swrc_pkg::CFG_RELIABLE: reliable_reg <= cfg_wdata;
                swrc_pkg::CFG_PEER:     peer_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Latched input item.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser;
            ser_reg  <= s_tdata[30:0];
            rel_reg  <= s_tdata[31];
            el_reg   <= s_tdata[47:32];
        end
    end

    // Send queue storage.
    always_ff @(posedge aclk) begin
        if (cmd.fifo_push) begin
            mem[tail_ix] <= {rel_reg, ser_reg};
        end
        if (cmd.fifo_rd) begin
            rd_reg <= mem[head_reg];
        end
    end

    // Session state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peer_known_reg <= 1'b0;
            awaiting_reg   <= 1'b0;
            rs_reg         <= '0;
            awaited_reg    <= '0;
            cd_reg         <= '0;
            age_reg        <= '0;
            silence_reg    <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
        end else if (cmd.close_sess || cmd.open_sess) begin
            peer_known_reg <= cmd.open_sess;
            awaiting_reg   <= 1'b0;
            rs_reg         <= rs_open;
            awaited_reg    <= '0;
            cd_reg         <= '0;
            age_reg        <= '0;
            silence_reg    <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
        end else begin
            if (cmd.tick_age) begin
                if (awaiting_reg) begin
                    cd_reg  <= cd_dec;
                    age_reg <= age_sat;
                end
                silence_reg <= sil_sat;
            end
            if (cmd.tick_retx) begin
                cd_reg <= resend_reg;
            end
            if (cmd.clr_await) begin
                awaiting_reg <= 1'b0;
            end
            if (cmd.clr_silence) begin
                silence_reg <= '0;
            end
            if (cmd.set_rs) begin
                rs_reg <= ser_reg;
            end
            if (cmd.fifo_push) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.fifo_pop) begin
                head_reg  <= head_next;
                count_reg <= count_reg - 1'b1;
                if (rd_reg[31]) begin
                    awaiting_reg <= 1'b1;
                    awaited_reg  <= rd_reg[30:0];
                    cd_reg       <= resend_reg;
                    age_reg      <= '0;
                end
            end
        end
    end

    // Result path: hold one result back until it is known whether it is the last.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                n_reg <= '0;
            end
            if (cmd.emit) begin
                n_reg          <= n_reg + 1'b1;
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pend_act_reg <= cmd.act;
            pend_ser_reg <= ser_mux;
            pend_rel_reg <= rel_mux;
        end
        if ((cmd.emit && pend_valid_reg) || cmd.finish) begin
            out_act_reg  <= pend_act_reg;
            out_ser_reg  <= pend_ser_reg;
            out_rel_reg  <= pend_rel_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rel_reg, out_ser_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/stop_and_wait_reliable_session_core.sv -----
// Top level of the stop-and-wait reliable session core for a single peer.
// One transaction is taken at a time; the next is accepted as soon as the last
// result of the previous one sits in the output register. An item gives at most 16
// results; each drained transmit costs one queue memory read and one emit step.
// Reset (aresetn low, synchronous) closes the session, empties the queue and
// restores the timer registers directly; there is no clearing pass.
`include "stop_and_wait_reliable_session_core_defines.svh"

module stop_and_wait_reliable_session_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // msg_serial[30:0], reliable[31], tick_gap_ms[47:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // serial[30:0], is_reliable[31]
    output logic [3:0]  m_tuser,   // action[3:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    swrc_pkg::swrc_cmd_t    cmd;
    swrc_pkg::swrc_status_t st;

    // Sequencer: walks each transaction through its decision steps.
    swrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: session registers, timers, send queue and result staging.
    swrc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Idle sequencer never leaves a result stranded in the staging slot.
    `SWRC_ASSERT_IMP(a_idle_no_pending, s_tready, !st.pend_valid)
    // A result is only staged when the staging slot can drain.
    `SWRC_ASSERT_IMP(a_emit_has_room, cmd.emit, st.emit_ok)
    // Never push into a full queue.
    `SWRC_ASSERT_IMP(a_push_not_full, cmd.fifo_push, !st.fifo_full)

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the stop-and-wait reliable session core.
module tb;

    localparam int DEPTH     = 16;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = swrc_pkg::FUNC_SEND;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = swrc_pkg::CFG_RESEND;
    logic [23:0] cfg_wdata = '0;

    stop_and_wait_reliable_session_core #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    // One expected result: action, serial, reliable flag, last marker.
    typedef struct packed {
        logic [3:0]  act;
        logic [30:0] ser;
        logic        rel;
        logic        lst;
    } outcome_t;

    outcome_t expected_q[$];

    // Shadow of the session state and timer registers.
    logic [23:0] resend_ms, reltmo_ms, peertmo_ms;
    logic        peer_up, waiting;
    logic [30:0] rx_hwm, wait_ser;
    logic [23:0] countdown, wait_age, quiet_ms;
    logic [31:0] queue_mem [DEPTH];
    int          q_head, q_count;

    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  cycle = 0;
    bit  hold_off = 1'b0;
    bit  sink_idle = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void push_outcome(logic [3:0] a, logic [30:0] s, logic r,
                                         ref int n);
        outcome_t o;
        if (n >= swrc_pkg::MAX_RESULTS) return;
        o.act = a; o.ser = s; o.rel = r; o.lst = 1'b0;
        expected_q.insert(expected_q.size(), o);
        n++;
    endfunction

    function automatic void end_session();
        peer_up = 0; rx_hwm = 0; waiting = 0; wait_ser = 0;
        countdown = 0; wait_age = 0; quiet_ms = 0; q_head = 0; q_count = 0;
    endfunction

    function automatic logic [23:0] sat24(logic [23:0] a, logic [15:0] b);
        logic [24:0] s;
        s = a + b;
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    function automatic void flush_queue(ref int n);
        logic [31:0] e;
        while (peer_up && !waiting && q_count > 0 && n < swrc_pkg::MAX_RESULTS) begin
            e = queue_mem[q_head];
            q_head = (q_head + 1) % DEPTH;
            q_count--;
            push_outcome(swrc_pkg::ACT_TX, e[30:0], e[31], n);
            if (e[31]) begin
                waiting = 1; wait_ser = e[30:0];
                countdown = resend_ms; wait_age = 0;
            end
        end
    endfunction

    // Work out the results of one accepted item and queue them.
    function automatic void predict_session(logic [1:0] fn, logic [30:0] ser,
                                            logic rel, logic [15:0] el);
        int n;
        int first;
        n = 0;
        first = expected_q.size();
        case (fn)
            swrc_pkg::FUNC_SEND: begin
                if (ser == 0) begin
                    push_outcome(swrc_pkg::ACT_TX, 0, rel, n);
                end else begin
                    if (!peer_up) begin
                        end_session(); peer_up = 1;
                        push_outcome(swrc_pkg::ACT_CONNECT, ser, 0, n);
                    end
                    if (q_count >= DEPTH) begin
                        push_outcome(swrc_pkg::ACT_FULL, ser, rel, n);
                    end else begin
                        queue_mem[(q_head + q_count) % DEPTH] = {rel, ser};
                        q_count++;
                    end
                    flush_queue(n);
                end
            end
            swrc_pkg::FUNC_TICK: begin
                if (peer_up) begin
                    if (waiting) begin
                        countdown = (countdown > el) ? countdown - el : 0;
                        wait_age = sat24(wait_age, el);
                        if (wait_age >= reltmo_ms) begin
                            push_outcome(swrc_pkg::ACT_DROP, wait_ser, 1, n);
                            waiting = 0;
                        end else if (countdown == 0) begin
                            countdown = resend_ms;
                            push_outcome(swrc_pkg::ACT_RETX, wait_ser, 1, n);
                        end
                    end
                    quiet_ms = sat24(quiet_ms, el);
                    if (quiet_ms >= peertmo_ms) begin
                        push_outcome(swrc_pkg::ACT_TIMEOUT, 0, 0, n);
                        end_session();
                    end else begin
                        flush_queue(n);
                    end
                end
            end
            swrc_pkg::FUNC_RX: begin
                if (!peer_up) begin
                    end_session(); peer_up = 1;
                    rx_hwm = (ser == 0) ? 31'd0 : ser - 31'd1;
                    push_outcome(swrc_pkg::ACT_CONNECT, ser, 0, n);
                end
                quiet_ms = 0;
                if (ser < rx_hwm && (ser <= swrc_pkg::RESET_WINDOW ||
                                     rx_hwm - ser > swrc_pkg::RESET_WINDOW)) begin
                    push_outcome(swrc_pkg::ACT_RESET, ser, 0, n);
                    end_session();
                end else begin
                    if (rel) push_outcome(swrc_pkg::ACT_ACK, ser, 0, n);
                    if (ser > rx_hwm) begin
                        rx_hwm = ser;
                        push_outcome(swrc_pkg::ACT_DELIVER, ser, 0, n);
                    end else begin
                        push_outcome(swrc_pkg::ACT_DUP, ser, 0, n);
                    end
                    flush_queue(n);
                end
            end
            default: begin
                if (peer_up && waiting && wait_ser == ser) begin
                    quiet_ms = 0; waiting = 0;
                end
                flush_queue(n);
            end
        endcase
        if (expected_q.size() > first) expected_q[$].lst = 1'b1;
    endfunction

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        outcome_t exp_o;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result, expected none, got act=%0d ser=%0d",
                             m_tuser, m_tdata[30:0]);
            end else begin
                exp_o = expected_q.pop_front();
                if (m_tuser !== exp_o.act || m_tdata[30:0] !== exp_o.ser ||
                    m_tdata[31] !== exp_o.rel || m_tlast !== exp_o.lst) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp act=%0d ser=%0d rel=%0d last=%0d %s%0d %0d %0d %0d",
                                 exp_o.act, exp_o.ser, exp_o.rel, exp_o.lst, "/ got ",
                                 m_tuser, m_tdata[30:0], m_tdata[31], m_tlast);
                end
            end
        end
    end

    // Result side: random stall per result while sink_idle is set, long hold-off when asked.
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            w = sink_idle ? int'($urandom_range(0, 9)) : 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    // Offer one item and hold it until taken; valid stays up for the next call.
    task automatic send_item(logic [1:0] fn, logic [30:0] ser, logic rel, logic [15:0] el,
                             bit gaps = 1);
        int w;
        w = gaps ? int'($urandom_range(0, 9)) : 0;
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {el, rel, ser};
        @(posedge aclk iff s_tready);
        predict_session(fn, ser, rel, el);
        items_sent++;
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            swrc_pkg::CFG_RESEND:   resend_ms = val;
            swrc_pkg::CFG_RELIABLE: reltmo_ms = val;
            default:                peertmo_ms = val;
        endcase
    endtask

    task automatic set_timers(logic [23:0] a, logic [23:0] b, logic [23:0] c);
        wait_quiet();
        write_reg(swrc_pkg::CFG_RESEND, a);
        write_reg(swrc_pkg::CFG_RELIABLE, b);
        write_reg(swrc_pkg::CFG_PEER, c);
        cfg_we <= 1'b0;
    endtask

    // Directed: service send, opening, full queue, acks, peer reset, extremes.
    task automatic test_directed();
        send_item(swrc_pkg::FUNC_TICK, 5, 0, 100);
        send_item(swrc_pkg::FUNC_ACK, 5, 0, 0);
        send_item(swrc_pkg::FUNC_SEND, 0, 1, 16'hFFFF);
        send_item(swrc_pkg::FUNC_SEND, 31'h7FFFFFFF, 1, 0);
        for (int i = 1; i <= 17; i++) send_item(swrc_pkg::FUNC_SEND, 31'(i), i[0], 0);
        send_item(swrc_pkg::FUNC_ACK, 31'h7FFFFFFF, 0, 0);
        send_item(swrc_pkg::FUNC_TICK, 0, 0, 400);
        send_item(swrc_pkg::FUNC_TICK, 0, 0, 200);
        send_item(swrc_pkg::FUNC_RX, 50, 1, 0);
        send_item(swrc_pkg::FUNC_RX, 45, 0, 0);
        send_item(swrc_pkg::FUNC_RX, 3, 1, 0);
        send_item(swrc_pkg::FUNC_RX, 0, 1, 0);
    endtask

    // Timers: zero and maximum registers, drop then drain, peer timeout.
    task automatic test_timers();
        set_timers(0, 0, 24'hFFFFFF);
        send_item(swrc_pkg::FUNC_SEND, 7, 1, 0);
        send_item(swrc_pkg::FUNC_SEND, 8, 0, 0);
        send_item(swrc_pkg::FUNC_TICK, 0, 0, 0);
        send_item(swrc_pkg::FUNC_SEND, 9, 1, 0);
        send_item(swrc_pkg::FUNC_TICK, 0, 0, 16'hFFFF);
        set_timers(24'hFFFFFF, 24'hFFFFFF, 0);
        send_item(swrc_pkg::FUNC_TICK, 0, 0, 1);
        set_timers(3, 20, 30);
        send_item(swrc_pkg::FUNC_RX, 1, 0, 0);
        for (int i = 0; i < 8; i++) send_item(swrc_pkg::FUNC_TICK, 0, 0, 4);
    endtask

    // Mostly well-formed session traffic with random content.
    task automatic test_random(int count, bit gaps);
        logic [1:0]  fn;
        logic [30:0] ser;
        logic [15:0] el;
        int          base;
        int          r;
        base = 100;
        for (int i = 0; i < count; i++) begin
            r = int'($urandom_range(0, 99));
            fn  = 2'($urandom_range(0, 3));
            el  = 16'($urandom_range(0, 20));
            ser = 31'(base + int'($urandom_range(0, 30)));
            if (r < 5) ser = 31'($urandom);
            else if (r < 8) ser = 0;
            else if (r < 11) el = 16'($urandom);
            else if (r < 20 && fn == swrc_pkg::FUNC_ACK && waiting) ser = wait_ser;
            else if (r < 40 && waiting) begin fn = swrc_pkg::FUNC_ACK; ser = wait_ser; end
            else if (r < 45) ser = rx_hwm - 31'($urandom_range(0, 15));
            base += int'($urandom_range(0, 3));
            send_item(fn, ser, 1'($urandom_range(0, 1)), el, gaps);
        end
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        set_timers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        hold_off = 1;
        for (int i = 1; i <= 20; i++) send_item(swrc_pkg::FUNC_SEND, 31'(1000 + i), 0, 0, 0);
    endtask

    initial begin
        resend_ms = swrc_pkg::RESEND_RST;
        reltmo_ms = swrc_pkg::RELIABLE_RST;
        peertmo_ms = swrc_pkg::PEER_RST;
        end_session();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_timers();
        test_backpressure();
        set_timers(swrc_pkg::RESEND_RST, swrc_pkg::RELIABLE_RST, swrc_pkg::PEER_RST);
        test_random(150, 1);
        set_timers(15, 60, 90);
        test_random(150, 1);
        sink_idle = 0;
        set_timers(5, 200, 24'hFFFFFF);
        test_random(130, 0);
        sink_idle = 1;
        wait_quiet();
        $display("Ran %0d items through send, tick, receive and ack paths, %0d results checked.",
                 items_sent, results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- stop_and_wait_reliable_session_core.f -----
+incdir+src
src/swrc_pkg.sv
src/swrc_ctrl.sv
src/swrc_dp.sv
src/stop_and_wait_reliable_session_core.sv
sim/tb.sv
